FILE: design/assert_macros.svh
// Assertion macros shared by the method walker RTL.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define PBW_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// When ante holds, cons holds in the same cycle.
`define PBW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// When ante holds, cons holds in the next cycle.
`define PBW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/pbw_pkg.sv
// Shared types and constants for the command buffer method walker.
// No dependencies; every design module but pbw_ram imports this package.
package pbw_pkg;

    localparam int MAX_WALK_DEF = 512;
    localparam int HIST_DEPTH   = 4096;
    localparam int HIST_AW      = $clog2(HIST_DEPTH);
    localparam int HIST_W       = 32;
    localparam int WORD_W       = 32;
    localparam int BLEN_W       = 17;
    localparam int CNT_W        = 13;
    localparam int MADDR_W      = 14;
    localparam int INIT_MIN_LEN = 8;

    localparam logic [2:0] OP_INC    = 3'd1;
    localparam logic [2:0] OP_NONINC = 3'd3;
    localparam logic [2:0] OP_IMM    = 3'd4;
    localparam logic [2:0] OP_ONEINC = 3'd5;

    localparam logic [MADDR_W-1:0] METHOD_LAUNCH_A = 14'h0318;
    localparam logic [MADDR_W-1:0] METHOD_LAUNCH_B = 14'h0320;
    localparam logic [MADDR_W-1:0] METHOD_LAUNCH_C = 14'h02b4;
    localparam logic [WORD_W-1:0]  INIT_BIND_WORD  = 32'h0000_c7c0;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_DATA    = 3'd1,
        KIND_STOP    = 3'd2,
        KIND_IGNORED = 3'd3,
        KIND_HIST    = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [2:0]         opcode;
        logic [2:0]         subchannel;
        logic [MADDR_W-1:0] method_addr;
        logic [CNT_W-1:0]   count;
        logic               is_launch;
        logic               buffer_has_launch;
        logic               is_compute_init;
        logic               last_word;
    } walk_res_t;

    typedef struct packed {
        logic              busy;
        logic [HIST_W-1:0] value;
    } hist_stat_t;

endpackage

FILE: design/pbw_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies. A read of an address written in the same cycle returns the old data.
module pbw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/pbw_walker.sv
// Header decoder and walk state for the method walker.
// Depends on pbw_pkg. Produces one decoded result per accepted beat.
module pbw_walker
    import pbw_pkg::*;
#(
    parameter int MAX_WALK = MAX_WALK_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              mode,
    input  logic [WORD_W-1:0] word,
    input  logic              first,
    input  logic [BLEN_W-1:0] buffer_len,
    output walk_res_t         res,
    output logic              hist_inc
);

    localparam int WL_W  = $clog2(MAX_WALK + 1);
    localparam int SUM_W = ((WL_W > CNT_W) ? WL_W : CNT_W) + 2;
    localparam logic [BLEN_W-1:0] MAX_BLEN = BLEN_W'(MAX_WALK);

    logic [WL_W-1:0]  pos_reg, pos_next;
    logic [WL_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic             stopped_reg, stopped_next;
    logic             launch_reg, launch_next;
    logic             cand_reg, cand_next;
    logic             flag_reg, flag_next;

    logic [WL_W-1:0]  eff_pos;
    logic [CNT_W-1:0] eff_left;
    logic             eff_stopped;
    logic             eff_launch;
    logic             eff_cand;
    logic             eff_flag;
    logic             in_buf;
    logic             last;
    logic [2:0]       op;
    logic [CNT_W-1:0] cnt;
    logic [11:0]      midx;
    logic [MADDR_W-1:0] maddr;
    logic             nd_ok;
    logic [CNT_W-1:0] nd;
    logic [SUM_W-1:0] need;
    logic             lau;

    always_comb
    begin
        // A first beat restarts the walk before the word itself is examined.
        if (first)
        begin
            len_next = (buffer_len > MAX_BLEN) ? WL_W'(MAX_WALK) : WL_W'(buffer_len);
        end
        else
        begin
            len_next = len_reg;
        end
        eff_pos     = first ? '0 : pos_reg;
        eff_left    = first ? '0 : left_reg;
        eff_stopped = first ? (len_next == '0) : stopped_reg;
        eff_launch  = first ? 1'b0 : launch_reg;
        eff_cand    = first ? 1'b0 : cand_reg;
        eff_flag    = first ? 1'b0 : flag_reg;

        in_buf   = eff_pos < len_next;
        last     = in_buf && (eff_pos == (len_next - WL_W'(1)));
        pos_next = in_buf ? (eff_pos + WL_W'(1)) : eff_pos;

        op    = word[31:29];
        cnt   = word[28:16];
        midx  = word[11:0];
        maddr = {midx, 2'b00};

        // The compute-init test looks at raw words 0 and 1, even after a stop.
        cand_next = (in_buf && eff_pos == '0) ? (op == OP_INC && midx == '0) : eff_cand;
        flag_next = (in_buf && eff_pos == WL_W'(1))
                  ? (eff_cand && word == INIT_BIND_WORD && len_next > WL_W'(INIT_MIN_LEN))
                  : eff_flag;

        nd_ok = (op inside {OP_INC, OP_NONINC, OP_ONEINC}) || op == OP_IMM;
        nd    = (op == OP_IMM) ? '0 : cnt;
        need  = SUM_W'(eff_pos) + SUM_W'(1) + SUM_W'(nd);
        lau   = maddr == METHOD_LAUNCH_A || maddr == METHOD_LAUNCH_B
             || maddr == METHOD_LAUNCH_C;
    end

    always_comb
    begin
        res          = '0;
        res.kind     = KIND_IGNORED;
        hist_inc     = 1'b0;
        left_next    = eff_left;
        stopped_next = eff_stopped;
        launch_next  = eff_launch;

        if (eff_stopped || !in_buf)
        begin
            res.kind = KIND_IGNORED;
        end
        else if (eff_left != '0)
        begin
            res.kind  = KIND_DATA;
            left_next = eff_left - CNT_W'(1);
        end
        else
        begin
            res.opcode      = op;
            res.subchannel  = word[15:13];
            res.method_addr = maddr;
            res.count       = cnt;
            if (!nd_ok || need > SUM_W'(len_next))
            begin
                res.kind     = KIND_STOP;
                stopped_next = 1'b1;
            end
            else
            begin
                res.kind      = KIND_HEADER;
                res.is_launch = lau;
                hist_inc      = 1'b1;
                left_next     = nd;
                if (lau)
                begin
                    launch_next = 1'b1;
                end
            end
        end

        if (pos_next >= len_next && left_next == '0)
        begin
            stopped_next = 1'b1;
        end

        res.buffer_has_launch = launch_next;
        res.is_compute_init   = flag_next;
        res.last_word         = last;

        if (mode)
        begin
            res      = '0;
            res.kind = KIND_HIST;
            hist_inc = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            len_reg     <= '0;
            left_reg    <= '0;
            stopped_reg <= 1'b1;
            launch_reg  <= 1'b0;
            cand_reg    <= 1'b0;
            flag_reg    <= 1'b0;
        end
        else if (step)
        begin
            pos_reg     <= pos_next;
            len_reg     <= len_next;
            left_reg    <= left_next;
            stopped_reg <= stopped_next;
            launch_reg  <= launch_next;
            cand_reg    <= cand_next;
            flag_reg    <= flag_next;
        end
    end

endmodule

FILE: design/pbw_hist.sv
// Per-method histogram: RAM, clearing sweep after reset, saturating increment.
// Depends on pbw_pkg and pbw_ram. Forwards the last write to cover a read-write overlap.
module pbw_hist
    import pbw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  logic [HIST_AW-1:0] rd_addr,
    input  logic               wr_en,
    input  logic [HIST_AW-1:0] s1_addr,
    output hist_stat_t         stat
);

    logic               clr_busy_reg, clr_busy_next;
    logic [HIST_AW-1:0] clr_addr_reg, clr_addr_next;
    logic               fwd_valid_reg;
    logic [HIST_AW-1:0] fwd_addr_reg;
    logic [HIST_W-1:0]  fwd_data_reg;

    logic [HIST_W-1:0]  rdata;
    logic [HIST_W-1:0]  cur;
    logic [HIST_W-1:0]  inc_val;
    logic               ram_we;
    logic [HIST_AW-1:0] ram_waddr;
    logic [HIST_W-1:0]  ram_wdata;

    pbw_ram #(
        .WIDTH(HIST_W),
        .DEPTH(HIST_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (rd_en),
        .raddr(rd_addr),
        .rdata(rdata)
    );

    always_comb
    begin
        // The entry read alongside the previous item's write-back sees stale RAM data.
        cur     = (fwd_valid_reg && fwd_addr_reg == s1_addr) ? fwd_data_reg : rdata;
        inc_val = (cur == '1) ? cur : (cur + HIST_W'(1));

        ram_we    = clr_busy_reg || wr_en;
        ram_waddr = clr_busy_reg ? clr_addr_reg : s1_addr;
        ram_wdata = clr_busy_reg ? '0 : inc_val;

        clr_addr_next = clr_addr_reg + HIST_AW'(1);
        clr_busy_next = clr_busy_reg && (clr_addr_reg != '1);

        stat.busy  = clr_busy_reg;
        stat.value = cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_next;
            end
            if (wr_en)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= inc_val;
        end
    end

endmodule

FILE: design/pushbuffer_method_walker.sv
// Command buffer method walker with a per-method histogram.
// Input channel (in_valid/in_stall): one beat per command word (mode 0) or per
// histogram read (mode 1). first and buffer_len open a new buffer; buffer_len is
// capped to MAX_WALK words. Output channel (out_valid/out_stall): one result beat
// per input beat, in order: word kind, decoded header fields, launch and
// compute-init flags, last-word mark, or the histogram count for a read.
// Each input beat passes the s1 stage, where the histogram RAM read completes,
// and then the output register, loaded as the increment is written back.
// Throughput is one beat per cycle while in_stall is low; the histogram
// read-modify-write forwards its last write so back-to-back headers on the
// same method count correctly. After reset the histogram is cleared by a sweep
// over all 4096 entries, one entry per cycle, during which in_stall stays high.
// When out_stall is high the output beat holds; the middle stage still takes
// one more beat, after which in_stall rises until the output drains.
// Depends on pbw_pkg, pbw_walker, pbw_hist, pbw_ram and assert_macros.svh.
`include "assert_macros.svh"

module pushbuffer_method_walker
    import pbw_pkg::*;
#(
    parameter int MAX_WALK = MAX_WALK_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic [WORD_W-1:0]  word,
    input  logic               first,
    input  logic [BLEN_W-1:0]  buffer_len,
    input  logic [HIST_AW-1:0] hist_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         word_kind,
    output logic [2:0]         opcode,
    output logic [2:0]         subchannel,
    output logic [MADDR_W-1:0] method_addr,
    output logic [CNT_W-1:0]   count,
    output logic               is_launch,
    output logic               buffer_has_launch,
    output logic               is_compute_init,
    output logic               last_word,
    output logic [HIST_W-1:0]  hist_value
);

    logic               in_accept;
    logic               s1_adv;
    walk_res_t          res;
    logic               hist_inc;
    hist_stat_t         stat;
    logic [HIST_AW-1:0] rd_addr;

    logic               s1_valid_reg;
    walk_res_t          s1_res_reg;
    logic               s1_inc_reg;
    logic [HIST_AW-1:0] s1_addr_reg;
    logic               out_valid_reg;
    walk_res_t          out_res_reg;
    logic [HIST_W-1:0]  out_hist_reg;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = stat.busy || (s1_valid_reg && !s1_adv);
    assign in_accept = in_valid && !in_stall;
    assign rd_addr   = mode ? hist_index : word[HIST_AW-1:0];

    pbw_walker #(
        .MAX_WALK(MAX_WALK)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (in_accept && !mode),
        .mode      (mode),
        .word      (word),
        .first     (first),
        .buffer_len(buffer_len),
        .res       (res),
        .hist_inc  (hist_inc)
    );

    pbw_hist u_hist (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (in_accept),
        .rd_addr(rd_addr),
        .wr_en  (s1_adv && s1_inc_reg),
        .s1_addr(s1_addr_reg),
        .stat   (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_inc_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_inc_reg   <= hist_inc;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
                s1_inc_reg   <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_res_reg  <= res;
            s1_addr_reg <= rd_addr;
        end
        if (s1_adv)
        begin
            out_res_reg  <= s1_res_reg;
            out_hist_reg <= (s1_res_reg.kind == KIND_HIST) ? stat.value : '0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign word_kind         = out_res_reg.kind;
    assign opcode            = out_res_reg.opcode;
    assign subchannel        = out_res_reg.subchannel;
    assign method_addr       = out_res_reg.method_addr;
    assign count             = out_res_reg.count;
    assign is_launch         = out_res_reg.is_launch;
    assign buffer_has_launch = out_res_reg.buffer_has_launch;
    assign is_compute_init   = out_res_reg.is_compute_init;
    assign last_word         = out_res_reg.last_word;
    assign hist_value        = out_hist_reg;

    `PBW_ASSERT_IMP(a_clear_blocks_input, stat.busy, in_stall, "beat accepted during histogram clear")
    `PBW_ASSERT_IMP(a_full_pipe_stalls, s1_valid_reg && out_valid_reg && out_stall, in_stall, "beat accepted into a full pipeline")
    `PBW_ASSERT_NXT(a_advance_fills_out, s1_adv, out_valid, "advanced beat missing at output")
    `PBW_ASSERT_IMP(a_hist_only_on_read, out_valid && word_kind != KIND_HIST, hist_value == '0, "histogram value on a word beat")

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the command buffer method walker.
// Predicts every result beat, including the method histogram, and compares it field by field.
// Depends on pbw_pkg and the pushbuffer_method_walker RTL.
module tb;
    import pbw_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BEATS = 1950;
    localparam int QUIET_AFTER = 1700;

    typedef struct {
        kind_t              kind;
        logic [2:0]         opcode;
        logic [2:0]         subchannel;
        logic [MADDR_W-1:0] method_addr;
        logic [CNT_W-1:0]   count;
        logic               is_launch;
        logic               seen_launch;
        logic               compute_init;
        logic               last;
        logic [HIST_W-1:0]  hist_value;
    } walk_beat_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               mode;
    logic [WORD_W-1:0]  word;
    logic               first;
    logic [BLEN_W-1:0]  buffer_len;
    logic [HIST_AW-1:0] hist_index;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         word_kind;
    logic [2:0]         opcode;
    logic [2:0]         subchannel;
    logic [MADDR_W-1:0] method_addr;
    logic [CNT_W-1:0]   count;
    logic               is_launch;
    logic               buffer_has_launch;
    logic               is_compute_init;
    logic               last_word;
    logic [HIST_W-1:0]  hist_value;

    // Shadow copy of the walker state.
    logic [HIST_W-1:0]  method_hist [HIST_DEPTH];
    logic [9:0]         walk_pos;
    logic [9:0]         walk_len;
    logic [CNT_W-1:0]   words_owed;
    logic               walk_done;
    logic               launch_flag;
    logic               bind_candidate;
    logic               bind_flag;

    walk_beat_t         expected_beats [$];
    walk_beat_t         head_beat;
    int                 error_cnt;
    int                 checked_cnt;
    int                 decoded_cnt;
    int                 cycle_cnt;
    int                 stall_left;
    bit                 quiet;

    pushbuffer_method_walker u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .mode              (mode),
        .word              (word),
        .first             (first),
        .buffer_len        (buffer_len),
        .hist_index        (hist_index),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .word_kind         (word_kind),
        .opcode            (opcode),
        .subchannel        (subchannel),
        .method_addr       (method_addr),
        .count             (count),
        .is_launch         (is_launch),
        .buffer_has_launch (buffer_has_launch),
        .is_compute_init   (is_compute_init),
        .last_word         (last_word),
        .hist_value        (hist_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Receiver side: random stall bursts, no new ones once the quiet phase starts.
    initial
    begin
        out_stall = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && !quiet && $urandom_range(0, 11) == 0)
                stall_left = $urandom_range(1, 15);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH beat %0d %s: got %0h, want %0h", checked_cnt, what, got, want);
        error_cnt++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (expected_beats.size() == 0)
                report_mismatch("unexpected result beat", 32'(word_kind), 32'd0);
            else
            begin
                head_beat = expected_beats.pop_front();
                check_field("word_kind", 32'(word_kind), 32'(head_beat.kind));
                check_field("opcode", 32'(opcode), 32'(head_beat.opcode));
                check_field("subchannel", 32'(subchannel), 32'(head_beat.subchannel));
                check_field("method_addr", 32'(method_addr), 32'(head_beat.method_addr));
                check_field("count", 32'(count), 32'(head_beat.count));
                check_field("is_launch", 32'(is_launch), 32'(head_beat.is_launch));
                check_field("buffer_has_launch", 32'(buffer_has_launch),
                            32'(head_beat.seen_launch));
                check_field("is_compute_init", 32'(is_compute_init),
                            32'(head_beat.compute_init));
                check_field("last_word", 32'(last_word), 32'(head_beat.last));
                check_field("hist_value", hist_value, head_beat.hist_value);
            end
            checked_cnt++;
        end
    end

    // Steps the shadow walker for a word beat or reads its histogram, then queues the result.
    task automatic walk_predict(input logic m, input logic [31:0] w, input logic f,
                                input logic [16:0] bl, input logic [11:0] hi);
        walk_beat_t e;
        logic [9:0] p;
        logic       in_buf;
        logic [2:0] op;
        int         nd;
        logic       lau;

        e.kind = KIND_IGNORED;
        e.opcode = '0;
        e.subchannel = '0;
        e.method_addr = '0;
        e.count = '0;
        e.is_launch = 1'b0;
        e.seen_launch = 1'b0;
        e.compute_init = 1'b0;
        e.last = 1'b0;
        e.hist_value = '0;
        if (m)
        begin
            e.kind = KIND_HIST;
            e.hist_value = method_hist[hi];
        end
        else
        begin
            if (f)
            begin
                walk_len = (bl > MAX_WALK_DEF) ? 10'(MAX_WALK_DEF) : bl[9:0];
                walk_pos = '0;
                words_owed = '0;
                walk_done = (walk_len == 0);
                launch_flag = 1'b0;
                bind_candidate = 1'b0;
                bind_flag = 1'b0;
            end
            in_buf = walk_pos < walk_len;
            p = walk_pos;
            e.last = in_buf && (p == walk_len - 10'd1);
            if (in_buf)
                walk_pos++;
            // The compute-init test sees raw words 0 and 1, stopped or not.
            if (in_buf && p == 0)
                bind_candidate = (w[31:29] == OP_INC) && (w[11:0] == 12'h000);
            if (in_buf && p == 1)
                bind_flag = bind_candidate && (w == INIT_BIND_WORD) && (walk_len > INIT_MIN_LEN);
            if (walk_done || !in_buf)
                e.kind = KIND_IGNORED;
            else if (words_owed > 0)
            begin
                e.kind = KIND_DATA;
                words_owed--;
            end
            else
            begin
                op = w[31:29];
                e.opcode = op;
                e.count = w[28:16];
                e.subchannel = w[15:13];
                e.method_addr = {w[11:0], 2'b00};
                case (op)
                    OP_INC, OP_NONINC, OP_ONEINC: nd = int'(w[28:16]);
                    OP_IMM:                       nd = 0;
                    default:                      nd = -1;
                endcase
                if (nd < 0 || int'(p) + 1 + nd > int'(walk_len))
                begin
                    e.kind = KIND_STOP;
                    walk_done = 1'b1;
                end
                else
                begin
                    lau = (e.method_addr == METHOD_LAUNCH_A) || (e.method_addr == METHOD_LAUNCH_B)
                        || (e.method_addr == METHOD_LAUNCH_C);
                    e.kind = KIND_HEADER;
                    if (method_hist[w[11:0]] != 32'hffff_ffff)
                        method_hist[w[11:0]]++;
                    words_owed = CNT_W'(nd);
                    if (lau)
                        launch_flag = 1'b1;
                    e.is_launch = lau;
                end
            end
            if (walk_pos >= walk_len && words_owed == 0)
                walk_done = 1'b1;
            e.seen_launch = launch_flag;
            e.compute_init = bind_flag;
        end
        decoded_cnt++;
        expected_beats.push_back(e);
    endtask

    // Drives one beat at the falling edge, possibly after a random idle burst,
    // and holds it until it is taken. in_valid stays high for a following beat.
    task automatic send_beat(input logic m, input logic [31:0] w, input logic f,
                             input logic [16:0] bl, input logic [11:0] hi);
        int gap;

        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 15);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        mode <= m;
        word <= w;
        first <= f;
        buffer_len <= bl;
        hist_index <= hi;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        walk_predict(m, w, f, bl, hi);
    endtask

    task automatic send_word(input logic [31:0] w, input logic f, input logic [16:0] bl);
        send_beat(1'b0, w, f, bl, 12'($urandom));
    endtask

    task automatic read_hist(input logic [11:0] hi);
        send_beat(1'b1, $urandom, 1'($urandom_range(0, 1)), 17'($urandom), hi);
    endtask

    function automatic logic [31:0] make_header(input logic [2:0] op, input logic [12:0] cnt,
                                                input logic [2:0] sub, input logic [11:0] idx);
        return {op, cnt, sub, 1'b0, idx};
    endfunction

    function automatic logic [11:0] pick_method();
        logic [11:0] pool [12] = '{12'h000, 12'h001, 12'h002, 12'h003, 12'h004, 12'h005,
                                   12'h006, 12'h007, 12'hfff, METHOD_LAUNCH_A[13:2],
                                   METHOD_LAUNCH_B[13:2], METHOD_LAUNCH_C[13:2]};
        if ($urandom_range(0, 99) < 45)
            return pool[$urandom_range(0, 11)];
        return 12'($urandom_range(0, HIST_DEPTH - 1));
    endfunction

    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(negedge clk);
    endtask

    // Entries 000 and fff read zero after the clear; words before any buffer are ignored.
    task automatic test_idle_reads();
        read_hist(12'h000);
        read_hist(12'hfff);
        send_word(32'h2001_0000, 1'b0, 17'd5);
    endtask

    // One compute-init buffer that walks every data-carrying opcode and a stop.
    task automatic test_opcodes();
        send_word(make_header(OP_INC, 13'd1, 3'd7, 12'h000), 1'b1, 17'd10);
        send_word(INIT_BIND_WORD, 1'b0, 17'd0);
        send_word(make_header(OP_IMM, 13'h1fff, 3'd0, METHOD_LAUNCH_C[13:2]), 1'b0, 17'h1ffff);
        send_word(make_header(OP_NONINC, 13'd2, 3'd3, METHOD_LAUNCH_A[13:2]), 1'b0, 17'd0);
        send_word(32'hffff_ffff, 1'b0, 17'd0);
        send_word(32'h0000_0000, 1'b0, 17'd0);
        send_word(make_header(OP_ONEINC, 13'd0, 3'd5, METHOD_LAUNCH_B[13:2]), 1'b0, 17'd0);
        send_word(make_header(3'd0, 13'd1, 3'd1, 12'h123), 1'b0, 17'd0);
        send_word(make_header(OP_INC, 13'd0, 3'd2, 12'h001), 1'b0, 17'd0);
        send_word(make_header(OP_IMM, 13'd0, 3'd2, 12'h002), 1'b0, 17'd0);
        // Past the end of the buffer.
        send_word(make_header(OP_IMM, 13'd0, 3'd2, 12'h003), 1'b0, 17'd0);
        read_hist(12'h000);
        read_hist(METHOD_LAUNCH_A[13:2]);
    endtask

    // Empty buffers, length caps, data running past the end and the other stop opcodes.
    task automatic test_buffer_limits();
        send_word(make_header(OP_IMM, 13'd4, 3'd0, 12'h010), 1'b1, 17'd0);
        send_word(make_header(OP_IMM, 13'd4, 3'd0, 12'h010), 1'b0, 17'd0);
        send_word(32'hffff_ffff, 1'b1, 17'h1ffff);
        send_word(make_header(OP_INC, 13'd5, 3'd4, 12'h020), 1'b1, 17'd2);
        send_word(make_header(3'd2, 13'd0, 3'd0, 12'h030), 1'b1, 17'h10000);
        send_word(make_header(3'd6, 13'd0, 3'd0, 12'h040), 1'b1, 17'd1);
        send_word(make_header(OP_IMM, 13'h0aaa, 3'd6, 12'hfff), 1'b1, 17'd1);
        read_hist(12'hfff);
        read_hist(12'h010);
    endtask

    // One buffer: mostly well-formed headers with random content, with
    // histogram reads, noise beats, truncation and overrun mixed in.
    task automatic send_random_buffer();
        int          r;
        int          blen;
        int          eff;
        int          nwords;
        int          pending;
        int          room;
        int          cnt;
        bit          bind_start;
        bit          gen_stopped;
        logic [2:0]  op;
        logic [31:0] w;

        r = $urandom_range(0, 99);
        if (r < 62)
            blen = $urandom_range(1, 24);
        else if (r < 77)
            blen = $urandom_range(25, 64);
        else if (r < 89)
            blen = $urandom_range(9, 16);
        else if (r < 95)
            blen = $urandom_range(1, 8);
        else if (r < 98)
            blen = 0;
        else
            blen = $urandom_range(65, 131071);
        bind_start = (r >= 77 && r < 89) || $urandom_range(0, 19) == 0;
        eff = (blen > MAX_WALK_DEF) ? MAX_WALK_DEF : blen;
        nwords = eff;
        if (eff > 64 && $urandom_range(0, 7) != 0)
            nwords = $urandom_range(1, 64);
        if (eff > 0 && $urandom_range(0, 9) == 0)
            nwords = $urandom_range(1, eff);
        if ($urandom_range(0, 7) == 0)
            nwords += $urandom_range(1, 3);
        if (nwords == 0)
            nwords = 1;
        pending = 0;
        gen_stopped = 1'b0;
        for (int i = 0; i < nwords; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                read_hist(pick_method());
            if (i > 0 && $urandom_range(0, 39) == 0)
                send_word($urandom, $urandom_range(0, 3) == 0, 17'($urandom));
            room = eff - i - 1;
            if (room < 0)
                room = 0;
            w = $urandom;
            if (i == 0 && bind_start)
            begin
                cnt = $urandom_range(1, 3);
                w[31:29] = OP_INC;
                w[28:16] = 13'(cnt);
                w[11:0] = 12'h000;
                if (cnt > room)
                    gen_stopped = 1'b1;
                else
                    pending = cnt;
            end
            else if (i == 1 && bind_start && pending > 0)
            begin
                w = INIT_BIND_WORD;
                pending--;
            end
            else if (gen_stopped || pending > 0)
            begin
                if (pending > 0)
                    pending--;
            end
            else
            begin
                if ($urandom_range(0, 99) < 88)
                begin
                    case ($urandom_range(0, 3))
                        0:       op = OP_INC;
                        1:       op = OP_NONINC;
                        2:       op = OP_IMM;
                        default: op = OP_ONEINC;
                    endcase
                end
                else
                    op = 3'($urandom_range(0, 7));
                if (op == OP_IMM || $urandom_range(0, 19) == 0)
                    cnt = $urandom_range(0, 8191);
                else
                    cnt = $urandom_range(0, (room < 6) ? room : 6);
                w[31:29] = op;
                w[28:16] = 13'(cnt);
                w[11:0] = pick_method();
                if (op == OP_INC || op == OP_NONINC || op == OP_ONEINC)
                begin
                    if (cnt > room)
                        gen_stopped = 1'b1;
                    else
                        pending = cnt;
                end
                else if (op != OP_IMM)
                    gen_stopped = 1'b1;
            end
            send_word(w, i == 0, (i == 0) ? 17'(blen) : 17'($urandom));
        end
    endtask

    task automatic test_random_walks();
        int buf_cnt;

        buf_cnt = 0;
        decoded_cnt = 0;
        while (decoded_cnt < RANDOM_BEATS)
        begin
            send_random_buffer();
            buf_cnt++;
            // Let the pipeline run dry once with the sender holding off.
            if (buf_cnt == 25)
                wait_drain();
            if (decoded_cnt >= QUIET_AFTER)
                quiet = 1'b1;
        end
    endtask

    initial
    begin
        error_cnt = 0;
        checked_cnt = 0;
        decoded_cnt = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = 1'b0;
        word = '0;
        first = 1'b0;
        buffer_len = '0;
        hist_index = '0;
        for (int i = 0; i < HIST_DEPTH; i++)
            method_hist[i] = '0;
        walk_pos = '0;
        walk_len = '0;
        words_owed = '0;
        walk_done = 1'b1;
        launch_flag = 1'b0;
        bind_candidate = 1'b0;
        bind_flag = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_reads();
        test_opcodes();
        test_buffer_limits();
        test_random_walks();

        wait_drain();
        repeat (8) @(posedge clk);
        if (expected_beats.size() != 0)
            report_mismatch("result beats never arrived", 32'(expected_beats.size()), 32'd0);
        if (error_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/pbw_pkg.sv
design/pbw_ram.sv
design/pbw_walker.sv
design/pbw_hist.sv
design/pushbuffer_method_walker.sv
sim/tb.sv
